@@ sv/midpoint_ellipse_rasterizer_assert.svh @@
// Assertion macros shared by the ellipse rasteriser RTL.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef MIDPOINT_ELLIPSE_RASTERIZER_ASSERT_SVH
`define MIDPOINT_ELLIPSE_RASTERIZER_ASSERT_SVH
`ifndef SYNTHESIS
`define MER_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define MER_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);
`else
`define MER_ASSERT_IMP(label, ante, cons, msg)
`define MER_ASSERT_ALWAYS(label, cond, msg)
`endif
`endif

@@ sv/mer_pkg.sv @@
package mer_pkg;

  localparam int COORD_BITS = 10;
  localparam int PIX_BITS   = COORD_BITS + 2;
  localparam int X_BITS     = COORD_BITS + 1;
  localparam int Y_BITS     = COORD_BITS + 2;
  localparam int SQ_BITS    = 2 * COORD_BITS;
  localparam int PROD_BITS  = 3 * COORD_BITS;
  localparam int DELTA_BITS = 3 * COORD_BITS + 3;
  localparam int DEC_BITS   = 4 * COORD_BITS + 8;
  localparam int COLOR_BITS = 8;
  localparam int APB_DATA_BITS = 32;
  localparam int APB_ADDR_BITS = 3;

  // Command codes of the request channel.
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  // Register index of pixel_color, taken from paddr[2].
  localparam logic REG_PIXEL_COLOR = 1'b0;

  // Control of the shared adder: subtract flag and extra carry in.
  typedef struct packed {
    logic sub;
    logic cin;
  } alu_ctrl_t;

  function automatic logic signed [DEC_BITS-1:0] sext_delta(
    input logic signed [DELTA_BITS-1:0] v);
    sext_delta = {{(DEC_BITS-DELTA_BITS){v[DELTA_BITS-1]}}, v};
  endfunction

  function automatic logic signed [DEC_BITS-1:0] zext_sq(input logic [SQ_BITS-1:0] v);
    zext_sq = {{(DEC_BITS-SQ_BITS){1'b0}}, v};
  endfunction

  function automatic logic signed [DEC_BITS-1:0] zext_prod(input logic [PROD_BITS-1:0] v);
    zext_prod = {{(DEC_BITS-PROD_BITS){1'b0}}, v};
  endfunction

endpackage

@@ sv/midpoint_ellipse_rasterizer.sv @@
// Midpoint ellipse rasteriser. A start request (cmd 0) loads the centre and
// the semiaxes and produces no result; each step request (cmd 1) produces the
// four mirrored pixels of the current point, last set on the fourth, or one
// result with finished and last set once the ellipse is complete or when no
// ellipse is loaded. The block works on one request at a time and drops
// in_stall_o only when it is idle. All arithmetic goes through one registered
// 20x10 multiplier and one shared 48-bit adder under a small sequencer, so
// the adder sets the clock period. A start is accepted, squares both
// semiaxes, forms a_sq*b and sets up the decision term. A step is
// accepted, tests the region, corrects the decision term when it crosses
// into region two, decides, presents the four pixels (waiting while the
// output is stalled) and then advances the decision terms. A finished
// result follows acceptance, the region test and the decision, and waits
// while the output is stalled. The result register lets the next
// request be accepted while the last result still waits to be taken.
// pixel_color is written through the APB-style port at byte address 0 and
// reads back there.
`include "midpoint_ellipse_rasterizer_assert.svh"

module midpoint_ellipse_rasterizer (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Request channel.
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 in_cmd_i,
  input  logic [mer_pkg::COORD_BITS-1:0]        in_center_x_i,
  input  logic [mer_pkg::COORD_BITS-1:0]        in_center_y_i,
  input  logic [mer_pkg::COORD_BITS-1:0]        in_semi_a_i,
  input  logic [mer_pkg::COORD_BITS-1:0]        in_semi_b_i,
  // Result channel.
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [mer_pkg::PIX_BITS-1:0]   out_pixel_x_o,
  output logic signed [mer_pkg::PIX_BITS-1:0]   out_pixel_y_o,
  output logic [mer_pkg::COLOR_BITS-1:0]        out_color_o,
  output logic                                 out_last_o,
  output logic                                 out_finished_o,
  // Configuration port.
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [mer_pkg::APB_ADDR_BITS-1:0]     paddr,
  input  logic [mer_pkg::APB_DATA_BITS-1:0]     pwdata,
  output logic [mer_pkg::APB_DATA_BITS-1:0]     prdata,
  output logic                                 pready
);
  import mer_pkg::*;

  // Sequencer states.
  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_SQA  = 5'd1;   // multiply a by a
  localparam logic [4:0] S_SQB  = 5'd2;   // store a_sq, multiply b by b
  localparam logic [4:0] S_ASB  = 5'd3;   // store b_sq, multiply a_sq by b
  localparam logic [4:0] S_INI1 = 5'd4;   // decision = b_sq - a_sq*b
  localparam logic [4:0] S_INI2 = 5'd5;   // decision += a_sq/4
  localparam logic [4:0] S_CHK  = 5'd6;   // region switch test, tmp = dx + dy
  localparam logic [4:0] S_COR1 = 5'd7;   // tmp = 3*(a_sq-b_sq)/2 - tmp
  localparam logic [4:0] S_COR2 = 5'd8;   // decision += tmp/2
  localparam logic [4:0] S_ACT  = 5'd9;   // decide between pixels and finished
  localparam logic [4:0] S_FIN  = 5'd10;
  localparam logic [4:0] S_PIX  = 5'd11;
  localparam logic [4:0] S_U1   = 5'd12;
  localparam logic [4:0] S_U2   = 5'd13;
  localparam logic [4:0] S_U3   = 5'd14;
  localparam logic [4:0] S_U4   = 5'd15;
  localparam logic [4:0] S_U5   = 5'd16;
  localparam logic [4:0] S_V1   = 5'd17;
  localparam logic [4:0] S_V2   = 5'd18;
  localparam logic [4:0] S_V3   = 5'd19;
  localparam logic [4:0] S_V4   = 5'd20;
  localparam logic [4:0] S_V5   = 5'd21;

  logic [4:0] state_q, state_d;

  // Ellipse state.
  logic [X_BITS-1:0]            cur_x_q, cur_x_d;
  logic signed [Y_BITS-1:0]     cur_y_q, cur_y_d;
  logic [COORD_BITS-1:0]        ctr_x_q, ctr_x_d;
  logic [COORD_BITS-1:0]        ctr_y_q, ctr_y_d;
  logic [SQ_BITS-1:0]           a_sq_q, a_sq_d;
  logic [SQ_BITS-1:0]           b_sq_q, b_sq_d;
  logic signed [DELTA_BITS-1:0] dx_q, dx_d;
  logic signed [DELTA_BITS-1:0] dy_q, dy_d;
  logic signed [DEC_BITS-1:0]   dec_q, dec_d;
  logic signed [DEC_BITS-1:0]   tmp_q, tmp_d;
  logic                         region_two_q, region_two_d;
  logic                         active_q, active_d;
  logic [COORD_BITS-1:0]        semi_a_q, semi_a_d;
  logic [COORD_BITS-1:0]        semi_b_q, semi_b_d;
  logic [1:0]                   pix_idx_q, pix_idx_d;
  logic [COLOR_BITS-1:0]        color_cfg_q;

  // Result register.
  logic                         out_valid_q, out_valid_d;
  logic signed [PIX_BITS-1:0]   out_px_q, out_px_d;
  logic signed [PIX_BITS-1:0]   out_py_q, out_py_d;
  logic [COLOR_BITS-1:0]        out_col_q, out_col_d;
  logic                         out_last_q, out_last_d;
  logic                         out_fin_q, out_fin_d;

  // Shared units.
  logic [SQ_BITS-1:0]           mul_a;
  logic [COORD_BITS-1:0]        mul_b;
  logic [PROD_BITS-1:0]         prod;
  logic signed [DEC_BITS-1:0]   alu_a, alu_b, alu_sum;
  alu_ctrl_t                    alu_ctrl;

  logic in_accept;
  logic out_free;
  logic cfg_write;

  // Region switch correction term 3*(a_sq - b_sq)/2, truncated toward zero.
  // It is held in a register, as a_sq and b_sq only change on a start.
  logic signed [SQ_BITS+2:0]    sq_diff;
  logic signed [SQ_BITS+2:0]    sq_diff3;
  logic signed [SQ_BITS+2:0]    sq_half_d;
  logic signed [SQ_BITS+2:0]    sq_half_q;

  logic signed [PIX_BITS-1:0]   pix_x_pos, pix_x_neg, pix_y_pos, pix_y_neg;
  logic                         going_dead;

  mer_mul u_mul (
    .clk_i   (clk_i),
    .mul_a_i (mul_a),
    .mul_b_i (mul_b),
    .prod_o  (prod)
  );

  mer_alu u_alu (
    .op_a_i (alu_a),
    .op_b_i (alu_b),
    .ctrl_i (alu_ctrl),
    .sum_o  (alu_sum)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // Configuration port: single register, no wait states.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == REG_PIXEL_COLOR) ?
                     {{(APB_DATA_BITS-COLOR_BITS){1'b0}}, color_cfg_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_cfg_q <= '0;
    end else if (cfg_write && (paddr[2] == REG_PIXEL_COLOR)) begin
      color_cfg_q <= pwdata[COLOR_BITS-1:0];
    end
  end

  assign sq_diff   = $signed({3'b000, a_sq_q}) - $signed({3'b000, b_sq_q});
  assign sq_diff3  = sq_diff + (sq_diff <<< 1);
  assign sq_half_d = (sq_diff3 + $signed({{(SQ_BITS+2){1'b0}}, sq_diff3[SQ_BITS+2]})) >>> 1;

  // Mirrored coordinates, wrapping modulo the pixel width.
  assign pix_x_pos = $signed({2'b00, ctr_x_q} + {1'b0, cur_x_q});
  assign pix_x_neg = $signed({2'b00, ctr_x_q} - {1'b0, cur_x_q});
  assign pix_y_pos = $signed({2'b00, ctr_y_q}) + cur_y_q;
  assign pix_y_neg = $signed({2'b00, ctr_y_q}) - cur_y_q;

  // The ellipse ends once region two has taken y below zero, or when none is loaded.
  assign going_dead = !active_q || (region_two_q && cur_y_q[Y_BITS-1]);

  always_comb begin
    state_d      = state_q;
    cur_x_d      = cur_x_q;
    cur_y_d      = cur_y_q;
    ctr_x_d      = ctr_x_q;
    ctr_y_d      = ctr_y_q;
    a_sq_d       = a_sq_q;
    b_sq_d       = b_sq_q;
    dx_d         = dx_q;
    dy_d         = dy_q;
    dec_d        = dec_q;
    tmp_d        = tmp_q;
    region_two_d = region_two_q;
    active_d     = active_q;
    semi_a_d     = semi_a_q;
    semi_b_d     = semi_b_q;
    pix_idx_d    = pix_idx_q;
    out_px_d     = out_px_q;
    out_py_d     = out_py_q;
    out_col_d    = out_col_q;
    out_last_d   = out_last_q;
    out_fin_d    = out_fin_q;
    out_valid_d  = out_valid_q && out_stall_i;
    mul_a        = '0;
    mul_b        = '0;
    alu_a        = dec_q;
    alu_b        = '0;
    alu_ctrl     = '{sub: 1'b0, cin: 1'b0};

    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          if (in_cmd_i == CMD_START) begin
            ctr_x_d  = in_center_x_i;
            ctr_y_d  = in_center_y_i;
            semi_a_d = in_semi_a_i;
            semi_b_d = in_semi_b_i;
            state_d  = S_SQA;
          end else begin
            state_d = S_CHK;
          end
        end
      end
      S_SQA: begin
        mul_a   = {{(SQ_BITS-COORD_BITS){1'b0}}, semi_a_q};
        mul_b   = semi_a_q;
        state_d = S_SQB;
      end
      S_SQB: begin
        a_sq_d  = prod[SQ_BITS-1:0];
        mul_a   = {{(SQ_BITS-COORD_BITS){1'b0}}, semi_b_q};
        mul_b   = semi_b_q;
        state_d = S_ASB;
      end
      S_ASB: begin
        b_sq_d  = prod[SQ_BITS-1:0];
        mul_a   = a_sq_q;
        mul_b   = semi_b_q;
        state_d = S_INI1;
      end
      S_INI1: begin
        alu_a    = zext_sq(b_sq_q);
        alu_b    = zext_prod(prod);
        alu_ctrl = '{sub: 1'b1, cin: 1'b0};
        dec_d    = alu_sum;
        dy_d     = $signed({{(DELTA_BITS-PROD_BITS-1){1'b0}}, prod, 1'b0});
        state_d  = S_INI2;
      end
      S_INI2: begin
        alu_a        = dec_q;
        alu_b        = zext_sq(a_sq_q >> 2);
        dec_d        = alu_sum;
        cur_x_d      = '0;
        cur_y_d      = $signed({2'b00, semi_b_q});
        dx_d         = '0;
        region_two_d = 1'b0;
        active_d     = 1'b1;
        state_d      = S_IDLE;
      end
      S_CHK: begin
        if (active_q && !region_two_q && !(dx_q < dy_q)) begin
          alu_a   = sext_delta(dx_q);
          alu_b   = sext_delta(dy_q);
          tmp_d   = alu_sum;
          state_d = S_COR1;
        end else begin
          state_d = S_ACT;
        end
      end
      S_COR1: begin
        alu_a    = {{(DEC_BITS-SQ_BITS-3){sq_half_q[SQ_BITS+2]}}, sq_half_q};
        alu_b    = tmp_q;
        alu_ctrl = '{sub: 1'b1, cin: 1'b0};
        tmp_d    = alu_sum;
        state_d  = S_COR2;
      end
      S_COR2: begin
        // Halving toward zero: arithmetic shift plus one for odd negatives.
        alu_a        = dec_q;
        alu_b        = tmp_q >>> 1;
        alu_ctrl     = '{sub: 1'b0, cin: tmp_q[DEC_BITS-1] & tmp_q[0]};
        dec_d        = alu_sum;
        region_two_d = 1'b1;
        state_d      = S_ACT;
      end
      S_ACT: begin
        pix_idx_d = '0;
        if (going_dead) begin
          active_d = 1'b0;
          state_d  = S_FIN;
        end else begin
          state_d = S_PIX;
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_px_d    = '0;
          out_py_d    = '0;
          out_col_d   = '0;
          out_last_d  = 1'b1;
          out_fin_d   = 1'b1;
          state_d     = S_IDLE;
        end
      end
      S_PIX: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_px_d    = pix_idx_q[0] ? pix_x_neg : pix_x_pos;
          out_py_d    = pix_idx_q[1] ? pix_y_neg : pix_y_pos;
          out_col_d   = color_cfg_q;
          out_last_d  = (pix_idx_q == 2'd3);
          out_fin_d   = 1'b0;
          pix_idx_d   = pix_idx_q + 2'd1;
          if (pix_idx_q == 2'd3) begin
            state_d = region_two_q ? S_V1 : S_U1;
          end
        end
      end
      // Region one: y moves down on a positive decision, x always steps.
      S_U1: begin
        if (dec_q > 0) begin
          alu_a    = sext_delta(dy_q);
          alu_b    = zext_sq(a_sq_q) <<< 1;
          alu_ctrl = '{sub: 1'b1, cin: 1'b0};
          dy_d     = alu_sum[DELTA_BITS-1:0];
          cur_y_d  = cur_y_q - Y_BITS'(1);
          state_d  = S_U2;
        end else begin
          state_d = S_U3;
        end
      end
      S_U2: begin
        alu_b    = sext_delta(dy_q);
        alu_ctrl = '{sub: 1'b1, cin: 1'b0};
        dec_d    = alu_sum;
        state_d  = S_U3;
      end
      S_U3: begin
        alu_a   = sext_delta(dx_q);
        alu_b   = zext_sq(b_sq_q) <<< 1;
        dx_d    = alu_sum[DELTA_BITS-1:0];
        cur_x_d = cur_x_q + X_BITS'(1);
        state_d = S_U4;
      end
      S_U4: begin
        alu_b   = sext_delta(dx_q);
        dec_d   = alu_sum;
        state_d = S_U5;
      end
      S_U5: begin
        alu_b   = zext_sq(b_sq_q);
        dec_d   = alu_sum;
        state_d = S_IDLE;
      end
      // Region two: x moves on a negative decision, y always steps down.
      S_V1: begin
        if (dec_q < 0) begin
          alu_a   = sext_delta(dx_q);
          alu_b   = zext_sq(b_sq_q) <<< 1;
          dx_d    = alu_sum[DELTA_BITS-1:0];
          cur_x_d = cur_x_q + X_BITS'(1);
          state_d = S_V2;
        end else begin
          state_d = S_V3;
        end
      end
      S_V2: begin
        alu_b   = sext_delta(dx_q);
        dec_d   = alu_sum;
        state_d = S_V3;
      end
      S_V3: begin
        alu_a    = sext_delta(dy_q);
        alu_b    = zext_sq(a_sq_q) <<< 1;
        alu_ctrl = '{sub: 1'b1, cin: 1'b0};
        dy_d     = alu_sum[DELTA_BITS-1:0];
        cur_y_d  = cur_y_q - Y_BITS'(1);
        state_d  = S_V4;
      end
      S_V4: begin
        alu_b   = zext_sq(a_sq_q);
        dec_d   = alu_sum;
        state_d = S_V5;
      end
      S_V5: begin
        alu_b    = sext_delta(dy_q);
        alu_ctrl = '{sub: 1'b1, cin: 1'b0};
        dec_d    = alu_sum;
        state_d  = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cur_x_q      <= '0;
      cur_y_q      <= '0;
      ctr_x_q      <= '0;
      ctr_y_q      <= '0;
      a_sq_q       <= '0;
      b_sq_q       <= '0;
      dx_q         <= '0;
      dy_q         <= '0;
      dec_q        <= '0;
      region_two_q <= 1'b0;
      active_q     <= 1'b0;
      pix_idx_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      cur_x_q      <= cur_x_d;
      cur_y_q      <= cur_y_d;
      ctr_x_q      <= ctr_x_d;
      ctr_y_q      <= ctr_y_d;
      a_sq_q       <= a_sq_d;
      b_sq_q       <= b_sq_d;
      dx_q         <= dx_d;
      dy_q         <= dy_d;
      dec_q        <= dec_d;
      region_two_q <= region_two_d;
      active_q     <= active_d;
      pix_idx_q    <= pix_idx_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload and scratch registers.
  always_ff @(posedge clk_i) begin
    tmp_q      <= tmp_d;
    sq_half_q  <= sq_half_d;
    semi_a_q   <= semi_a_d;
    semi_b_q   <= semi_b_d;
    out_px_q   <= out_px_d;
    out_py_q   <= out_py_d;
    out_col_q  <= out_col_d;
    out_last_q <= out_last_d;
    out_fin_q  <= out_fin_d;
  end

  assign out_valid_o    = out_valid_q;
  assign out_pixel_x_o  = out_px_q;
  assign out_pixel_y_o  = out_py_q;
  assign out_color_o    = out_col_q;
  assign out_last_o     = out_last_q;
  assign out_finished_o = out_fin_q;

  `MER_ASSERT_IMP(a_fin_is_last, out_valid_o && out_finished_o, out_last_o,
    "finished without last")
  `MER_ASSERT_IMP(a_fin_blank, out_valid_o && out_finished_o,
    (out_pixel_x_o == 0) && (out_pixel_y_o == 0) && (out_color_o == 0),
    "finished result carries data")
  `MER_ASSERT_ALWAYS(a_y_floor, !(cur_y_q < -2'sd1), "current y below minus one")
  `MER_ASSERT_IMP(a_pix_active, state_q == S_PIX, active_q, "pixels emitted with no ellipse")

endmodule

@@ sv/mer_mul.sv @@
module mer_mul (
  input  logic                          clk_i,
  input  logic [mer_pkg::SQ_BITS-1:0]    mul_a_i,
  input  logic [mer_pkg::COORD_BITS-1:0] mul_b_i,
  output logic [mer_pkg::PROD_BITS-1:0]  prod_o
);
  import mer_pkg::*;

  logic [PROD_BITS-1:0] prod_d;
  logic [PROD_BITS-1:0] prod_q;

  // Unsigned product, registered before anything uses it.
  assign prod_d = PROD_BITS'({{COORD_BITS{1'b0}}, mul_a_i} * {{SQ_BITS{1'b0}}, mul_b_i});

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign prod_o = prod_q;

endmodule

@@ sv/mer_alu.sv @@
module mer_alu (
  input  logic signed [mer_pkg::DEC_BITS-1:0] op_a_i,
  input  logic signed [mer_pkg::DEC_BITS-1:0] op_b_i,
  input  mer_pkg::alu_ctrl_t                  ctrl_i,
  output logic signed [mer_pkg::DEC_BITS-1:0] sum_o
);
  import mer_pkg::*;

  logic [DEC_BITS-1:0] op_b_x;
  logic [DEC_BITS-1:0] carry;

  // Subtraction is addition of the complement with a carry in.
  assign op_b_x = ctrl_i.sub ? ~op_b_i : op_b_i;
  assign carry  = {{(DEC_BITS-1){1'b0}}, ctrl_i.sub | ctrl_i.cin};
  assign sum_o  = $signed(op_a_i + op_b_x + carry);

endmodule
